/* rtl/core/epoch_seconds_to_calendar_top_macros.svh */
// Assertion macros used by the calendar conversion pipeline.
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ES2C_CHK_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define ES2C_CHK_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/es2c_pkg.sv */
// Types and constants for the epoch seconds to calendar converter.
package es2c_pkg;

    localparam int EPOCH_W     = 33;
    localparam int T_W         = 34;   // epoch plus offset, signed
    localparam int OFFSET_W    = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int STAGES      = 8;

    // seconds -> days: drop 7 bits (86400 = 128 * 675), then reciprocal of 675
    localparam int          DAY_SHIFT     = 7;
    localparam logic [26:0] DAY_MUL       = 27'd101806633;
    localparam int          DAY_MUL_SHIFT = 36;
    localparam logic [9:0]  DAY_DIV       = 10'd675;
    localparam logic [16:0] DAYS_LIMIT    = 17'd47482;   // 2100-01-01
    localparam logic [16:0] DAYS_TO_1970  = 17'd731;     // from 1968-01-01

    localparam logic [16:0] QUAD_MUL       = 17'd91868;  // 1/1461
    localparam int          QUAD_MUL_SHIFT = 27;
    localparam logic [10:0] QUAD_DAYS      = 11'd1461;

    localparam logic [17:0] HOUR_MUL       = 18'd149131; // 1/3600
    localparam int          HOUR_MUL_SHIFT = 29;
    localparam logic [11:0] SECS_HOUR      = 12'd3600;

    localparam logic [12:0] MIN_MUL        = 13'd4370;   // 1/60
    localparam int          MIN_MUL_SHIFT  = 18;
    localparam logic [5:0]  SECS_MIN       = 6'd60;

    localparam logic [10:0] WDAY_MUL       = 11'd1171;   // 1/7
    localparam int          WDAY_MUL_SHIFT = 13;

    localparam logic [7:0]  YEAR_BASE      = 8'd68;
    localparam logic [10:0] DAYS_YEAR      = 11'd365;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOCAL_MODE    = 1'b0,
        REG_LOCATION_WORD = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_NEGATIVE = 2'd1,
        ERR_RANGE    = 2'd2
    } err_code_t;

    typedef struct packed {
        logic                local_mode;
        logic                dst;
        logic [OFFSET_W-1:0] offset;
    } cfg_t;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] mday;
        logic [3:0] month;
        logic [7:0] years;
        logic [2:0] weekday;
        logic [8:0] doy;
        logic       dst;
        err_code_t  err;
    } result_t;

    typedef struct packed {
        logic dst;
        logic neg;
        logic ovf;
    } tag_t;

endpackage

/* rtl/core/epoch_seconds_to_calendar_top.sv */
// Top level of the epoch seconds to calendar converter.
//
// Converts a signed 33-bit count of seconds since 1970-01-01 00:00 UTC into a
// broken-down calendar date, valid from 1970 through 2099. One beat is taken
// per clock unless a stall has filled every stage; each result passes through the
// eight-stage pipeline (offset add, day reciprocal multiply, day remainder,
// group and hour multiplies, group remainder, year and minute, month split,
// weekday modulo and result register). Every stage holds its own valid bit, so
// a stall on the master side only backs up to the input once every stage is
// occupied; bubbles are squeezed out. No memory, no clearing pass after reset.
// In local mode the signed 24-bit offset in location bits 23..0 is added
// before conversion and bit 31 is reported as the DST flag. A time below zero
// returns error code 1, a time at or beyond 2100-01-01 returns error code 2,
// both with all other fields zero. Write configuration only while idle.
module epoch_seconds_to_calendar_top
    import es2c_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input beats
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [32:0] epoch_seconds, rest zero
    // result beats
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // second, minute, hour, day_of_month,
                                                   // month, years_since_1900, weekday,
                                                   // day_of_year, dst_flag, zero pad
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // error_code
);

    logic                local_mode_reg;
    logic                loc_dst_reg;
    logic [OFFSET_W-1:0] loc_offset_reg;
    cfg_t                cfg;
    result_t             res;

    // config registers; index is only one bit wide so every code is a register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mode_reg <= 1'b0;
            loc_dst_reg    <= 1'b0;
            loc_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_LOCAL_MODE:
                begin
                    local_mode_reg <= cfg_wdata[0];
                end
                REG_LOCATION_WORD:
                begin
                    loc_dst_reg    <= cfg_wdata[CFG_DATA_W-1];
                    loc_offset_reg <= cfg_wdata[OFFSET_W-1:0];
                end
            endcase
        end
    end

    assign cfg.local_mode = local_mode_reg;
    assign cfg.dst        = loc_dst_reg;
    assign cfg.offset     = loc_offset_reg;

    es2c_pipe u_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_epoch  (signed'(s_axis_tdata[EPOCH_W-1:0])),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // pack result fields, lowest bit first
    assign m_axis_tdata = {1'b0, res.dst, res.doy, res.weekday, res.years,
                           res.month, res.mday, res.hour, res.minute, res.second};
    assign m_axis_tuser = res.err;

endmodule

/* rtl/core/es2c_pipe.sv */
// Eight-stage conversion pipeline with per-stage valid and bubble collapse.
`include "epoch_seconds_to_calendar_top_macros.svh"

module es2c_pipe
    import es2c_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [EPOCH_W-1:0] in_epoch,
    output logic                      out_valid,
    input  logic                      out_ready,
    output result_t                   out_res
);

    logic [STAGES:1] v_reg;
    logic [STAGES:1] rdy;
    tag_t            tag_reg [1:STAGES-1];

    // stage 1: offset add
    logic signed [T_W-1:0] t_next, t1_reg, ofs_ext;
    // stage 2: reciprocal product for days
    logic [25:0] q1;
    logic [52:0] day_prod_next, day_prod_reg;
    logic [25:0] q1_reg;
    logic [6:0]  r1_reg;
    // stage 3: days, seconds of day
    logic [16:0] days;
    logic [26:0] days_x;
    logic [25:0] day_rem;
    logic [15:0] d3_reg;
    logic [16:0] secs3_reg;
    logic        ovf_next;
    // stage 4: four-year groups, hour
    logic [32:0] quad_prod;
    logic [34:0] hour_prod;
    logic [5:0]  quads4_reg;
    logic [4:0]  hour4_reg;
    logic [15:0] d4_reg;
    logic [16:0] secs4_reg;
    // stage 5: day within group, seconds within hour
    logic [10:0] extra5_reg;
    logic [7:0]  ybase5_reg;
    logic [11:0] remh5_reg;
    logic [4:0]  hour5_reg;
    // stage 6: year within group, minute
    logic [10:0] e1;
    logic [1:0]  xy;
    logic [8:0]  doy_next;
    logic [24:0] min_prod;
    logic [8:0]  doy6_reg;
    logic [7:0]  years6_reg;
    logic        leap6_reg;
    logic [5:0]  minute6_reg;
    logic [11:0] remh6_reg;
    logic [4:0]  hour6_reg;
    // stage 7: month split, second, weekday sum
    logic [8:0]  feb_end, r_late;
    logic        late;
    logic [7:0]  rr, mbase;
    logic [2:0]  off;
    logic [3:0]  mon_next;
    logic [4:0]  mday_next;
    logic [7:0]  ym1;
    logic [5:0]  second7_reg, minute7_reg;
    logic [4:0]  hour7_reg, mday7_reg;
    logic [3:0]  mon7_reg;
    logic [7:0]  years7_reg;
    logic [8:0]  doy7_reg;
    logic [9:0]  wsum7_reg;
    // stage 8: weekday modulo, error masking
    logic [20:0] wday_prod;
    logic [7:0]  wq;
    logic [2:0]  wday;
    result_t     res_next, res_reg;

    // ready chain: a stage moves when it is empty or the one after it moves
    always_comb
    begin
        rdy[STAGES] = !v_reg[STAGES] || out_ready;
        for (int i = STAGES - 1; i >= 1; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i + 1];
        end
    end

    assign in_ready  = rdy[1];
    assign out_valid = v_reg[STAGES];
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int i = 2; i <= STAGES; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i - 1];
                end
            end
        end
    end

    // ---- stage 1
    always_comb
    begin
        ofs_ext = cfg.local_mode ? T_W'(signed'(cfg.offset)) : '0;
        t_next  = T_W'(in_epoch) + ofs_ext;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            t1_reg         <= t_next;
            tag_reg[1].dst <= cfg.local_mode & cfg.dst;
            tag_reg[1].neg <= t_next[T_W-1];
            tag_reg[1].ovf <= 1'b0;
        end
    end

    // ---- stage 2
    always_comb
    begin
        q1            = t1_reg[EPOCH_W-1:DAY_SHIFT];
        day_prod_next = 53'(q1) * 53'(DAY_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            day_prod_reg <= day_prod_next;
            q1_reg       <= q1;
            r1_reg       <= t1_reg[DAY_SHIFT-1:0];
            tag_reg[2]   <= tag_reg[1];
        end
    end

    // ---- stage 3
    always_comb
    begin
        days     = day_prod_reg[52:DAY_MUL_SHIFT];
        days_x   = 27'(days) * 27'(DAY_DIV);
        day_rem  = q1_reg - days_x[25:0];
        ovf_next = (days >= DAYS_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            d3_reg         <= 16'(days + DAYS_TO_1970);
            secs3_reg      <= {day_rem[9:0], r1_reg};
            tag_reg[3].dst <= tag_reg[2].dst;
            tag_reg[3].neg <= tag_reg[2].neg;
            tag_reg[3].ovf <= ovf_next;
        end
    end

    // ---- stage 4
    always_comb
    begin
        quad_prod = 33'(d3_reg) * 33'(QUAD_MUL);
        hour_prod = 35'(secs3_reg) * 35'(HOUR_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            quads4_reg <= quad_prod[QUAD_MUL_SHIFT+5:QUAD_MUL_SHIFT];
            hour4_reg  <= hour_prod[HOUR_MUL_SHIFT+4:HOUR_MUL_SHIFT];
            d4_reg     <= d3_reg;
            secs4_reg  <= secs3_reg;
            tag_reg[4] <= tag_reg[3];
        end
    end

    // ---- stage 5
    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            extra5_reg <= 11'(d4_reg - 16'(16'(quads4_reg) * 16'(QUAD_DAYS)));
            ybase5_reg <= 8'({quads4_reg, 2'b00}) + YEAR_BASE;
            remh5_reg  <= 12'(secs4_reg - 17'(17'(hour4_reg) * 17'(SECS_HOUR)));
            hour5_reg  <= hour4_reg;
            tag_reg[5] <= tag_reg[4];
        end
    end

    // ---- stage 6
    always_comb
    begin
        e1 = extra5_reg - 11'd1;
        priority if (extra5_reg == '0)
            xy = 2'd0;
        else if (e1 >= 11'(3 * DAYS_YEAR))
            xy = 2'd3;
        else if (e1 >= 11'(2 * DAYS_YEAR))
            xy = 2'd2;
        else if (e1 >= DAYS_YEAR)
            xy = 2'd1;
        else
            xy = 2'd0;

        unique case (xy)
            2'd0:    doy_next = extra5_reg[8:0];
            2'd1:    doy_next = 9'(e1 - DAYS_YEAR);
            2'd2:    doy_next = 9'(e1 - 11'(2 * DAYS_YEAR));
            default: doy_next = 9'(e1 - 11'(3 * DAYS_YEAR));
        endcase

        min_prod = 25'(remh5_reg) * 25'(MIN_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            doy6_reg    <= doy_next;
            years6_reg  <= ybase5_reg + 8'(xy);
            leap6_reg   <= (xy == 2'd0);
            minute6_reg <= min_prod[MIN_MUL_SHIFT+5:MIN_MUL_SHIFT];
            remh6_reg   <= remh5_reg;
            hour6_reg   <= hour5_reg;
            tag_reg[6]  <= tag_reg[5];
        end
    end

    // ---- stage 7: March onward runs in two five-month blocks of 153 days
    always_comb
    begin
        feb_end   = leap6_reg ? 9'd60 : 9'd59;
        r_late    = doy6_reg - feb_end;
        late      = (r_late >= 9'd153);
        rr        = late ? 8'(r_late - 9'd153) : r_late[7:0];
        mon_next  = '0;
        mday_next = '0;

        priority if (rr >= 8'd122)
            off = 3'd4;
        else if (rr >= 8'd92)
            off = 3'd3;
        else if (rr >= 8'd61)
            off = 3'd2;
        else if (rr >= 8'd31)
            off = 3'd1;
        else
            off = 3'd0;

        unique case (off)
            3'd0:    mbase = 8'd0;
            3'd1:    mbase = 8'd31;
            3'd2:    mbase = 8'd61;
            3'd3:    mbase = 8'd92;
            default: mbase = 8'd122;
        endcase

        priority if (doy6_reg < feb_end)
        begin
            if (doy6_reg < 9'd31)
            begin
                mon_next  = 4'd0;
                mday_next = 5'(doy6_reg + 9'd1);
            end
            else
            begin
                mon_next  = 4'd1;
                mday_next = 5'(doy6_reg - 9'd30);
            end
        end
        else
        begin
            mon_next  = 4'(4'd2 + (late ? 4'd5 : 4'd0) + 4'(off));
            mday_next = 5'(rr - mbase + 8'd1);
        end

        ym1 = years6_reg - 8'd1;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            second7_reg <= 6'(remh6_reg - 12'(12'(minute6_reg) * 12'(SECS_MIN)));
            minute7_reg <= minute6_reg;
            hour7_reg   <= hour6_reg;
            mday7_reg   <= mday_next;
            mon7_reg    <= mon_next;
            years7_reg  <= years6_reg;
            doy7_reg    <= doy6_reg;
            wsum7_reg   <= 10'(years6_reg) + 10'(ym1[7:2]) + 10'(doy6_reg) + 10'd1;
            tag_reg[7]  <= tag_reg[6];
        end
    end

    // ---- stage 8: result register
    always_comb
    begin
        wday_prod = 21'(wsum7_reg) * 21'(WDAY_MUL);
        wq        = wday_prod[WDAY_MUL_SHIFT+7:WDAY_MUL_SHIFT];
        wday      = 3'(wsum7_reg - 10'(10'(wq) * 10'd7));

        res_next = '0;
        priority if (tag_reg[7].neg)
        begin
            res_next.err = ERR_NEGATIVE;
        end
        else if (tag_reg[7].ovf)
        begin
            res_next.err = ERR_RANGE;
        end
        else
        begin
            res_next.second  = second7_reg;
            res_next.minute  = minute7_reg;
            res_next.hour    = hour7_reg;
            res_next.mday    = mday7_reg;
            res_next.month   = mon7_reg;
            res_next.years   = years7_reg;
            res_next.weekday = wday;
            res_next.doy     = doy7_reg;
            res_next.dst     = tag_reg[7].dst;
            res_next.err     = ERR_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[8])
        begin
            res_reg <= res_next;
        end
    end

    `ES2C_CHK_IMP(a_full_stall, !in_ready, out_valid && !out_ready,
        "input stalled while pipeline has room")
    `ES2C_CHK_IMP(a_err_zero, out_valid && (out_res.err != ERR_OK),
        out_res[$bits(result_t)-1:2] == '0, "error result carries nonzero fields")
    `ES2C_CHK_IMP(a_ok_range, out_valid && (out_res.err == ERR_OK),
        out_res.second < 6'd60 && out_res.minute < 6'd60 && out_res.hour < 5'd24 &&
        out_res.month < 4'd12 && out_res.mday != 5'd0 && out_res.weekday < 3'd7,
        "calendar field out of range")
    `ES2C_CHK_NXT(a_stage_hold, v_reg[4] && !rdy[5], v_reg[4] && $stable(d4_reg),
        "stalled stage lost its beat")

endmodule
